/* sv/fpr_pkg.sv */
// ----------------------------------------------------------------------------
// fpr_pkg
// Types and constants shared by the framed packet receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned LEN_W     = 6;
	localparam int unsigned INDEX_W   = 5;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned CFG_IDX_W = 2;

	// largest payload a frame may carry, longer settings are clipped to it
	localparam logic [LEN_W-1:0] PAYLOAD_MAX = LEN_W'(32);
	localparam logic [LEN_W-1:0] LEN_RESET   = LEN_W'(8);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CHECK   = 2'd2,
		PH_END     = 2'd3
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATA     = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_CSUM_ERR = 2'd2,
		KIND_BAD_END  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_BYTE = 2'd0,
		REG_END_BYTE   = 2'd1,
		REG_PAYLOAD_LEN = 2'd2,
		REG_UNUSED     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                valid;
		kind_t               kind;
		logic [BYTE_W-1:0]   data_byte;
		logic [INDEX_W-1:0]  byte_index;
	} fpr_result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] end_byte;
		logic [LEN_W-1:0]  payload_length;
	} fpr_cfg_t;

endpackage

`default_nettype wire

/* sv/fpr_parser.sv */
// ----------------------------------------------------------------------------
// fpr_parser
// Frame state machine: start hunt, payload count, checksum and end check.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_parser (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              step,
	input  wire  [fpr_pkg::BYTE_W-1:0]       rx_byte,
	input  fpr_pkg::fpr_cfg_t                cfg,
	output fpr_pkg::fpr_result_t             res
);

	fpr_pkg::phase_t                 phase_q, phase_d;
	logic [fpr_pkg::LEN_W-1:0]       count_q, count_d;
	logic [fpr_pkg::BYTE_W-1:0]      sum_q, sum_d;
	logic [fpr_pkg::BYTE_W-1:0]      csum_q, csum_d;
	logic [fpr_pkg::LEN_W-1:0]       eff_len;
	logic [fpr_pkg::LEN_W-1:0]       count_inc;

	// zero length acts as one, long lengths clip to the maximum
	always_comb begin
		eff_len = cfg.payload_length;
		if (eff_len == '0) begin
			eff_len = fpr_pkg::LEN_W'(1);
		end
		if (eff_len > fpr_pkg::PAYLOAD_MAX) begin
			eff_len = fpr_pkg::PAYLOAD_MAX;
		end
	end

	assign count_inc = count_q + fpr_pkg::LEN_W'(1);

	always_comb begin
		phase_d        = phase_q;
		count_d        = count_q;
		sum_d          = sum_q;
		csum_d         = csum_q;
		res.valid      = 1'b0;
		res.kind       = fpr_pkg::KIND_DATA;
		res.data_byte  = '0;
		res.byte_index = '0;
		case (phase_q)
			fpr_pkg::PH_HUNT: begin
				if (rx_byte == cfg.start_byte) begin
					phase_d = fpr_pkg::PH_PAYLOAD;
					count_d = '0;
					sum_d   = rx_byte;
				end
			end
			fpr_pkg::PH_PAYLOAD: begin
				res.valid      = 1'b1;
				res.kind       = fpr_pkg::KIND_DATA;
				res.data_byte  = rx_byte;
				res.byte_index = count_q[fpr_pkg::INDEX_W-1:0];
				sum_d          = sum_q + rx_byte;
				count_d        = count_inc;
				if (count_inc >= eff_len) begin
					phase_d = fpr_pkg::PH_CHECK;
				end
			end
			fpr_pkg::PH_CHECK: begin
				csum_d  = rx_byte;
				phase_d = fpr_pkg::PH_END;
			end
			fpr_pkg::PH_END: begin
				res.valid = 1'b1;
				if (rx_byte != cfg.end_byte) begin
					res.kind = fpr_pkg::KIND_BAD_END;
				end else if (fpr_pkg::BYTE_W'(sum_q + rx_byte) != csum_q) begin
					res.kind = fpr_pkg::KIND_CSUM_ERR;
				end else begin
					res.kind = fpr_pkg::KIND_GOOD;
				end
				phase_d = fpr_pkg::PH_HUNT;
			end
			default: begin
				phase_d = fpr_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fpr_pkg::PH_HUNT;
			count_q <= '0;
			sum_q   <= '0;
			csum_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			csum_q  <= csum_d;
		end
	end

endmodule

`default_nettype wire

/* sv/framed_packet_receiver.sv */
// ----------------------------------------------------------------------------
// framed_packet_receiver
// Start/end delimited frame receiver with an 8-bit sum checksum.
// ----------------------------------------------------------------------------
// Bytes from a serial receiver enter on the s_ stream, one per word. The block
// hunts for start_byte, passes payload_length payload bytes out on the m_
// stream with their index, takes a checksum byte, and on the end byte reports
// frame good, checksum error or wrong end marker. Start, checksum and hunted
// bytes give no output word.
// The user is to set registers through cfg_we/cfg_index/cfg_wdata only while
// the block is idle; the block itself does not enforce it. Throughput is one
// byte per cycle while the output side does not stall. An accepted byte is
// held in the input register, and its result word is loaded from there into
// the output register, which drives m_tvalid and is taken on m_tready.
// When m_tready is low the output word holds; the input register still drains
// bytes that give no word, and the input side stalls only when a byte with a
// result finds the output register full.
// Reset clears the frame state to hunting, empties both registers and loads
// start_byte 0, end_byte 0 and payload_length 8.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_packet_receiver (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [fpr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [fpr_pkg::BYTE_W-1:0]         cfg_wdata,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [7:0]                         s_tdata,   // rx_byte[7:0]
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [15:0]                        m_tdata,   // data_byte[7:0], byte_index[12:8]
	output logic [fpr_pkg::KIND_W-1:0]         m_tuser    // kind[1:0]
);

	fpr_pkg::fpr_cfg_t               cfg_q;
	logic                            valid_s1;
	logic [fpr_pkg::BYTE_W-1:0]      rx_s1;
	fpr_pkg::fpr_result_t            res;
	logic                            out_valid_q;
	fpr_pkg::kind_t                  out_kind_q;
	logic [fpr_pkg::BYTE_W-1:0]      out_data_q;
	logic [fpr_pkg::INDEX_W-1:0]     out_index_q;
	logic                            out_free;
	logic                            advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte     <= '0;
			cfg_q.end_byte       <= '0;
			cfg_q.payload_length <= fpr_pkg::LEN_RESET;
		end else if (cfg_we) begin
			case (fpr_pkg::cfg_reg_t'(cfg_index))
				fpr_pkg::REG_START_BYTE:  cfg_q.start_byte <= cfg_wdata;
				fpr_pkg::REG_END_BYTE:    cfg_q.end_byte <= cfg_wdata;
				fpr_pkg::REG_PAYLOAD_LEN: cfg_q.payload_length <= cfg_wdata[fpr_pkg::LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;
	// a byte with no result never waits on the output side
	assign advance  = valid_s1 && (!res.valid || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rx_s1 <= s_tdata;
		end
	end

	fpr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (rx_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_kind_q  <= res.kind;
			out_data_q  <= res.data_byte;
			out_index_q <= res.byte_index;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_index_q, out_data_q};
	assign m_tuser  = out_kind_q;

	a_status_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != fpr_pkg::KIND_DATA) |-> (m_tdata == 16'h0000))
		else $error("status word carries nonzero data");

	a_held_byte_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(rx_s1))
		else $error("stalled input byte lost");

	a_result_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.valid |=> m_tvalid)
		else $error("result word dropped");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !(advance && res.valid))
		else $error("output word overwritten while stalled");

endmodule

`default_nettype wire
